>>> sv/pfpid_pkg.sv
// shared types, constants and helpers of the pressure filter and pid step
package pfpid_pkg;

  // fraction bits of pressures, errors and the drive
  localparam int FRAC_BITS = 16;

  localparam int RAW_W    = 16;
  localparam int PRES_W   = 32;
  localparam int DRIVE_W  = 20;
  localparam int ALPHA_W  = 17;
  localparam int GAIN_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // shared multiplier operand width and working accumulator width
  localparam int MUL_W = 33;
  localparam int ACC_W = 64;

  // shift from Q8.24 scale times count down to pressure fraction bits
  localparam int SCALE_SHIFT = 24 - FRAC_BITS;
  // alpha and gains carry 16 fraction bits
  localparam int WEIGHT_SHIFT = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam longint ONE      = longint'(1) << FRAC_BITS;
  localparam longint SAT_MAX  = 64'sd2147483647;
  localparam longint SAT_MIN  = -64'sd2147483648;
  localparam longint INTEG_LIM_L = (150 * ONE > SAT_MAX) ? SAT_MAX : 150 * ONE;
  localparam logic signed [PRES_W:0] INTEG_LIM = (PRES_W+1)'(INTEG_LIM_L);
  localparam longint DRIVE_HI = 7 * ONE;
  localparam longint DRIVE_LO = 3 * (ONE >> 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAW_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILT_ALPHA = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0]         raw_low;
    logic [RAW_W-1:0]         raw_high;
    logic [31:0]              count_scale;
    logic signed [PRES_W-1:0] pressure_offset;
    logic [ALPHA_W-1:0]       filter_alpha;
    logic [GAIN_W-1:0]        gain_p;
    logic [GAIN_W-1:0]        gain_i;
    logic [GAIN_W-1:0]        gain_d;
  } cfg_t;

  // operand pair of the shared multiplier
  typedef enum logic [2:0] {
    MUL_SCALE,
    MUL_ALPHA,
    MUL_BETA,
    MUL_P,
    MUL_I,
    MUL_D
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     take_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     pres_en;
    logic     filt_en;
    logic     err_en;
    logic     out_en;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [PRES_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [PRES_W-1:0] r;
    if (v > SAT_MAX) begin
      r = PRES_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = PRES_W'(SAT_MIN);
    end else begin
      r = v[PRES_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/pfpid_intf.sv
// valid/ready channel interfaces of the pressure filter and pid step
interface pfpid_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [pfpid_pkg::CFG_IDX_W-1:0]     index;
  logic [pfpid_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface pfpid_in_if;
  logic                                valid;
  logic                                ready;
  logic [pfpid_pkg::RAW_W-1:0]         raw_sample;
  logic signed [pfpid_pkg::PRES_W-1:0] target_pressure;
  modport source (output valid, raw_sample, target_pressure, input ready);
  modport sink (input valid, raw_sample, target_pressure, output ready);
endinterface

interface pfpid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pfpid_pkg::DRIVE_W-1:0] drive;
  logic signed [pfpid_pkg::PRES_W-1:0]  filtered_pressure;
  logic signed [pfpid_pkg::PRES_W-1:0]  control_error;
  modport source (output valid, drive, filtered_pressure, control_error, input ready);
  modport sink (input valid, drive, filtered_pressure, control_error, output ready);
endinterface

>>> sv/pfpid_regs.sv
// configuration register file
module pfpid_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfpid_cfg_if.sink           cfg_i,
  output pfpid_pkg::cfg_t     cfg_o
);

  pfpid_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_low         <= '0;
      cfg_q.raw_high        <= '1;
      cfg_q.count_scale     <= 32'd16777216;
      cfg_q.pressure_offset <= '0;
      cfg_q.filter_alpha    <= pfpid_pkg::ALPHA_W'(6554);
      cfg_q.gain_p          <= '0;
      cfg_q.gain_i          <= '0;
      cfg_q.gain_d          <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pfpid_pkg::REG_RAW_LOW:     cfg_q.raw_low <= cfg_i.data[pfpid_pkg::RAW_W-1:0];
        pfpid_pkg::REG_RAW_HIGH:    cfg_q.raw_high <= cfg_i.data[pfpid_pkg::RAW_W-1:0];
        pfpid_pkg::REG_COUNT_SCALE: cfg_q.count_scale <= cfg_i.data;
        pfpid_pkg::REG_PRES_OFFSET: cfg_q.pressure_offset <= cfg_i.data;
        pfpid_pkg::REG_FILT_ALPHA:  cfg_q.filter_alpha <= cfg_i.data[pfpid_pkg::ALPHA_W-1:0];
        pfpid_pkg::REG_GAIN_P:      cfg_q.gain_p <= cfg_i.data[pfpid_pkg::GAIN_W-1:0];
        pfpid_pkg::REG_GAIN_I:      cfg_q.gain_i <= cfg_i.data[pfpid_pkg::GAIN_W-1:0];
        pfpid_pkg::REG_GAIN_D:      cfg_q.gain_d <= cfg_i.data[pfpid_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/pfpid_ctrl.sv
// sequencer that steps one tick through the shared multiplier datapath
module pfpid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pfpid_pkg::status_t   status_i,
  output pfpid_pkg::cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MSCALE = 4'd1;
  localparam logic [3:0] S_PRES   = 4'd2;
  localparam logic [3:0] S_MALPHA = 4'd3;
  localparam logic [3:0] S_MBETA  = 4'd4;
  localparam logic [3:0] S_FILT   = 4'd5;
  localparam logic [3:0] S_ERR    = 4'd6;
  localparam logic [3:0] S_MP     = 4'd7;
  localparam logic [3:0] S_MI     = 4'd8;
  localparam logic [3:0] S_MD     = 4'd9;
  localparam logic [3:0] S_DRIVE  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.mul_sel = pfpid_pkg::MUL_SCALE;
    cmd_o.acc_op  = pfpid_pkg::ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = S_MSCALE;
        end
      end
      S_MSCALE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_SCALE;
        state_d       = S_PRES;
      end
      S_PRES: begin
        cmd_o.pres_en = 1'b1;
        state_d       = S_MALPHA;
      end
      S_MALPHA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_ALPHA;
        state_d       = S_MBETA;
      end
      S_MBETA: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_BETA;
        cmd_o.acc_op  = pfpid_pkg::ACC_LOAD;
        state_d       = S_FILT;
      end
      S_FILT: begin
        cmd_o.filt_en = 1'b1;
        state_d       = S_ERR;
      end
      S_ERR: begin
        cmd_o.err_en = 1'b1;
        state_d      = S_MP;
      end
      S_MP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_P;
        state_d       = S_MI;
      end
      S_MI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_I;
        cmd_o.acc_op  = pfpid_pkg::ACC_LOAD;
        state_d       = S_MD;
      end
      S_MD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pfpid_pkg::MUL_D;
        cmd_o.acc_op  = pfpid_pkg::ACC_ADD;
        state_d       = S_DRIVE;
      end
      S_DRIVE: begin
        // wait here while the previous result is still held
        if (status_i.out_free) begin
          cmd_o.out_en = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/pfpid_dp.sv
// datapath: input latch, shared multiplier, filter and pid state, result register
module pfpid_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pfpid_pkg::cfg_t                      cfg_i,
  input  pfpid_pkg::cmd_t                      cmd_i,
  output pfpid_pkg::status_t                   status_o,
  input  logic [pfpid_pkg::RAW_W-1:0]          raw_sample_i,
  input  logic signed [pfpid_pkg::PRES_W-1:0]  target_pressure_i,
  pfpid_out_if.source                          out_o
);

  localparam int PW = pfpid_pkg::PRES_W;
  localparam int MW = pfpid_pkg::MUL_W;
  localparam int AW = pfpid_pkg::ACC_W;
  localparam int DW = pfpid_pkg::DRIVE_W;

  // working registers
  logic [pfpid_pkg::RAW_W-1:0] sample_q;
  logic signed [PW-1:0]        target_q;
  logic signed [AW-1:0]        prod_q;
  logic signed [AW-1:0]        acc_q;
  logic signed [PW-1:0]        pres_q;
  logic signed [PW-1:0]        err_q;
  logic signed [PW:0]          deriv_q;
  // tick-to-tick state
  logic signed [PW-1:0]        smooth_q;
  logic signed [PW-1:0]        sum_q;
  logic signed [PW-1:0]        last_q;
  // result register
  logic                        out_valid_q;
  logic signed [DW-1:0]        drive_q;
  logic signed [PW-1:0]        filt_out_q;
  logic signed [PW-1:0]        err_out_q;

  logic [pfpid_pkg::RAW_W-1:0]   clamped;
  logic signed [pfpid_pkg::RAW_W:0] count;
  logic [pfpid_pkg::ALPHA_W-1:0] alpha_sat;
  logic [pfpid_pkg::ALPHA_W-1:0] beta;
  logic signed [MW-1:0]          mul_a, mul_b;
  logic signed [2*MW-1:0]        mul_p;
  logic signed [AW-1:0]          pres_sum;
  logic signed [PW-1:0]          pres_d;
  logic signed [AW-1:0]          mac_sum;
  logic signed [PW-1:0]          filt_d;
  logic signed [PW:0]            diff;
  logic signed [PW-1:0]          err_d;
  logic signed [PW:0]            sum_raw;
  logic signed [PW-1:0]          sum_d;
  logic signed [PW:0]            deriv_d;
  logic signed [AW-1:0]          pid;
  logic signed [AW-1:0]          drive_full;

  // clamp the sample; with an inverted range raw_low is taken below raw_low, raw_high otherwise
  always_comb begin
    if (sample_q < cfg_i.raw_low) begin
      clamped = cfg_i.raw_low;
    end else if (sample_q > cfg_i.raw_high) begin
      clamped = cfg_i.raw_high;
    end else begin
      clamped = sample_q;
    end
    count = $signed({1'b0, clamped}) - $signed({1'b0, cfg_i.raw_low});
  end

  always_comb begin
    if (cfg_i.filter_alpha > pfpid_pkg::ALPHA_ONE) begin
      alpha_sat = pfpid_pkg::ALPHA_ONE;
    end else begin
      alpha_sat = cfg_i.filter_alpha;
    end
    beta = pfpid_pkg::ALPHA_ONE - alpha_sat;
  end

  // operand select of the shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      pfpid_pkg::MUL_SCALE: begin
        mul_a = MW'(count);
        mul_b = $signed({1'b0, cfg_i.count_scale});
      end
      pfpid_pkg::MUL_ALPHA: begin
        mul_a = $signed(MW'(alpha_sat));
        mul_b = MW'(pres_q);
      end
      pfpid_pkg::MUL_BETA: begin
        mul_a = $signed(MW'(beta));
        mul_b = MW'(smooth_q);
      end
      pfpid_pkg::MUL_P: begin
        mul_a = $signed(MW'(cfg_i.gain_p));
        mul_b = MW'(err_q);
      end
      pfpid_pkg::MUL_I: begin
        mul_a = $signed(MW'(cfg_i.gain_i));
        mul_b = MW'(sum_q);
      end
      pfpid_pkg::MUL_D: begin
        mul_a = $signed(MW'(cfg_i.gain_d));
        mul_b = deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // scaled pressure plus offset
  assign pres_sum = (prod_q >>> pfpid_pkg::SCALE_SHIFT) + AW'(cfg_i.pressure_offset);
  assign pres_d   = pfpid_pkg::sat32(pres_sum);

  // both the filter and the pid close with acc plus the last product
  assign mac_sum = acc_q + prod_q;
  assign filt_d  = pfpid_pkg::sat32(mac_sum >>> pfpid_pkg::WEIGHT_SHIFT);
  assign pid     = mac_sum >>> pfpid_pkg::WEIGHT_SHIFT;

  // error, clamped integral and difference
  always_comb begin
    diff = (PW+1)'(target_q) - (PW+1)'(smooth_q);
    if (diff[PW] != diff[PW-1]) begin
      err_d = diff[PW] ? PW'(pfpid_pkg::SAT_MIN) : PW'(pfpid_pkg::SAT_MAX);
    end else begin
      err_d = diff[PW-1:0];
    end
    sum_raw = (PW+1)'(err_d) + (PW+1)'(sum_q);
    if (sum_raw > pfpid_pkg::INTEG_LIM) begin
      sum_d = PW'(pfpid_pkg::INTEG_LIM);
    end else if (sum_raw < -pfpid_pkg::INTEG_LIM) begin
      sum_d = PW'(-pfpid_pkg::INTEG_LIM);
    end else begin
      sum_d = sum_raw[PW-1:0];
    end
    deriv_d = (PW+1)'(err_d) - (PW+1)'(last_q);
  end

  // deadband: push nonzero drive into the allowed magnitude band
  always_comb begin
    if (pid < 0) begin
      if (pid < -pfpid_pkg::DRIVE_HI) begin
        drive_full = -pfpid_pkg::DRIVE_HI;
      end else if (pid > -pfpid_pkg::DRIVE_LO) begin
        drive_full = -pfpid_pkg::DRIVE_LO;
      end else begin
        drive_full = pid;
      end
    end else if (pid > 0) begin
      if (pid > pfpid_pkg::DRIVE_HI) begin
        drive_full = pfpid_pkg::DRIVE_HI;
      end else if (pid < pfpid_pkg::DRIVE_LO) begin
        drive_full = pfpid_pkg::DRIVE_LO;
      end else begin
        drive_full = pid;
      end
    end else begin
      drive_full = '0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q    <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.filt_en) begin
        smooth_q <= filt_d;
      end
      if (cmd_i.err_en) begin
        sum_q  <= sum_d;
        last_q <= err_d;
      end
      if (cmd_i.out_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      sample_q <= raw_sample_i;
      target_q <= target_pressure_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p[AW-1:0];
    end
    case (cmd_i.acc_op)
      pfpid_pkg::ACC_LOAD: acc_q <= prod_q;
      pfpid_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
      default: ;
    endcase
    if (cmd_i.pres_en) begin
      pres_q <= pres_d;
    end
    if (cmd_i.err_en) begin
      err_q   <= err_d;
      deriv_q <= deriv_d;
    end
    if (cmd_i.out_en) begin
      drive_q    <= drive_full[DW-1:0];
      filt_out_q <= smooth_q;
      err_out_q  <= err_q;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.drive             = drive_q;
  assign out_o.filtered_pressure = filt_out_q;
  assign out_o.control_error     = err_out_q;

endmodule

>>> sv/pressure_filter_pid_step.sv
// top level of the pressure filter and pid step
// input is taken only while idle, so a tick runs to its end before another is accepted;
// each tick takes six products through one 33x33 multiplier
// plus the pressure, filter, error and drive steps; a held result stalls only the drive step
// reset: filter state, integral, last error and output valid clear; registers take defaults
// configuration writes are taken every cycle
module pressure_filter_pid_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  pfpid_cfg_if.sink    cfg_i,
  pfpid_in_if.sink     in_i,
  pfpid_out_if.source  out_o
);

  // register file contents
  pfpid_pkg::cfg_t    cfg;
  // sequencer commands and datapath status
  pfpid_pkg::cmd_t    cmd;
  pfpid_pkg::status_t status;
  logic               in_ready;

  // config write transfer lands directly in the register file
  pfpid_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // sequencer: idle, scale, offset, two filter products, filter, error,
  // three pid products, then drive into the result register
  pfpid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // datapath with the result register that parts input from output
  pfpid_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .status_o          (status),
    .raw_sample_i      (in_i.raw_sample),
    .target_pressure_i (in_i.target_pressure),
    .out_o             (out_o)
  );

endmodule

>>> sv/pfpid_checker.sv
// port-level checks of the pressure filter and pid step, bound to the top level
module pfpid_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [pfpid_pkg::DRIVE_W-1:0] drive_i,
  input  logic signed [pfpid_pkg::PRES_W-1:0]  filtered_pressure_i,
  input  logic signed [pfpid_pkg::PRES_W-1:0]  control_error_i
);

  logic   in_xfer;
  longint drive_l;

  assign in_xfer = in_valid_i && in_ready_i;
  assign drive_l = longint'(drive_i);

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(drive_i) && $stable(filtered_pressure_i)
      && $stable(control_error_i))
    else $error("result changed while stalled");

  // drive is zero or within the deadband limits
  a_drive_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (drive_l == 0)
      || (drive_l >= pfpid_pkg::DRIVE_LO && drive_l <= pfpid_pkg::DRIVE_HI)
      || (drive_l <= -pfpid_pkg::DRIVE_LO && drive_l >= -pfpid_pkg::DRIVE_HI))
    else $error("drive outside deadband limits");

  // one tick at a time: no new input right after a transfer
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i)
    else $error("input taken while a tick is in progress");

endmodule

bind pressure_filter_pid_step pfpid_checker u_pfpid_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .drive_i             (out_o.drive),
  .filtered_pressure_i (out_o.filtered_pressure),
  .control_error_i     (out_o.control_error)
);

>>> test/tb.sv
// testbench of the pressure filter and pid step: self-checking, random idling, random settings
`timescale 1ns / 1ps

module tb;

  // run limit in clock cycles, far above the slowest correct run
  localparam int unsigned CYCLE_LIMIT = 200000;

  // fixed point constants of the control loop, derived here from the fraction width
  localparam longint UNIT        = longint'(1) << pfpid_pkg::FRAC_BITS;
  localparam longint INT32_HI    = 64'sd2147483647;
  localparam longint INT32_LO    = -64'sd2147483648;
  localparam longint WINDUP_CAP  = (150 * UNIT > INT32_HI) ? INT32_HI : 150 * UNIT;
  localparam longint DRIVE_CEIL  = 7 * UNIT;
  localparam longint DRIVE_FLOOR = 3 * (UNIT >> 1);
  localparam longint ALPHA_FULL  = 65536;

  // one control tick and the result it should produce
  typedef struct {
    logic [pfpid_pkg::RAW_W-1:0]         raw;
    logic signed [pfpid_pkg::PRES_W-1:0] target;
  } tick_t;

  typedef struct {
    logic signed [pfpid_pkg::DRIVE_W-1:0] drive;
    logic signed [pfpid_pkg::PRES_W-1:0]  filtered;
    logic signed [pfpid_pkg::PRES_W-1:0]  ctl_err;
  } loop_out_t;

  logic clk_i;
  logic rst_ni;

  pfpid_cfg_if cfg_if ();
  pfpid_in_if  in_if ();
  pfpid_out_if out_if ();

  pressure_filter_pid_step i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // register copy and loop state of the predictor
  pfpid_pkg::cfg_t                     regs;
  logic signed [pfpid_pkg::PRES_W-1:0] smooth_kpa;
  logic signed [pfpid_pkg::PRES_W-1:0] integ_kpa;
  logic signed [pfpid_pkg::PRES_W-1:0] prev_err;

  tick_t     pending_ticks[$];   // ticks waiting for the driver
  loop_out_t expected_outs[$];   // predicted results, oldest first
  int        ticks_in_flight;    // queued ticks whose result is not checked yet
  int        fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  tick_t     drv_tick;
  loop_out_t mon_want;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one tick of the loop: clamp and scale, smooth, error, pid, deadband
  function automatic loop_out_t control_tick(input logic [pfpid_pkg::RAW_W-1:0] raw,
                                             input logic signed [pfpid_pkg::PRES_W-1:0] target);
    longint    count;
    longint    kpa;
    longint    alpha;
    longint    filt;
    longint    err;
    longint    sum;
    longint    deriv;
    longint    pid;
    longint    drv;
    loop_out_t o;
    count = longint'(raw);
    // an inverted range lets the high limit win for anything not below the low one
    if (count < longint'(regs.raw_low)) begin
      count = longint'(regs.raw_low);
    end else if (count > longint'(regs.raw_high)) begin
      count = longint'(regs.raw_high);
    end
    kpa = (count - longint'(regs.raw_low)) * longint'(regs.count_scale);
    kpa = (kpa >>> pfpid_pkg::SCALE_SHIFT) + longint'($signed(regs.pressure_offset));
    kpa = clip(kpa, INT32_LO, INT32_HI);

    // weights above one are taken as one
    alpha = longint'(regs.filter_alpha);
    if (alpha > ALPHA_FULL) alpha = ALPHA_FULL;
    filt = (alpha * kpa + (ALPHA_FULL - alpha) * longint'(smooth_kpa)) >>> 16;
    filt = clip(filt, INT32_LO, INT32_HI);
    smooth_kpa = filt[pfpid_pkg::PRES_W-1:0];

    err = clip(longint'(target) - filt, INT32_LO, INT32_HI);
    sum = clip(longint'(integ_kpa) + err, -WINDUP_CAP, WINDUP_CAP);
    integ_kpa = sum[pfpid_pkg::PRES_W-1:0];
    deriv = err - longint'(prev_err);
    prev_err = err[pfpid_pkg::PRES_W-1:0];

    pid = longint'(regs.gain_p) * err + longint'(regs.gain_i) * sum
        + longint'(regs.gain_d) * deriv;
    pid = pid >>> 16;

    // push the drive out of the deadband, zero stays zero
    if (pid < 0) begin
      drv = clip(pid, -DRIVE_CEIL, -DRIVE_FLOOR);
    end else if (pid > 0) begin
      drv = clip(pid, DRIVE_FLOOR, DRIVE_CEIL);
    end else begin
      drv = 0;
    end

    o.drive    = drv[pfpid_pkg::DRIVE_W-1:0];
    o.filtered = filt[pfpid_pkg::PRES_W-1:0];
    o.ctl_err  = err[pfpid_pkg::PRES_W-1:0];
    return o;
  endfunction

  // driver: presents queued ticks, predicts each one at its transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_outs.push_back(control_tick(in_if.raw_sample, in_if.target_pressure));
      end
      // a held tick stays put until it is taken
      if (!in_if.valid || in_if.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick = pending_ticks.pop_front();
          in_if.valid           <= 1'b1;
          in_if.raw_sample      <= drv_tick.raw;
          in_if.target_pressure <= drv_tick.target;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_outs.size() == 0) begin
          $error("result with nothing expected: drive %0d", out_if.drive);
          fail_count++;
        end else begin
          mon_want = expected_outs.pop_front();
          ticks_in_flight--;
          if (out_if.drive !== mon_want.drive) begin
            $error("drive: expected %0d, got %0d", mon_want.drive, out_if.drive);
            fail_count++;
          end
          if (out_if.filtered_pressure !== mon_want.filtered) begin
            $error("filtered_pressure: expected %0d, got %0d",
                   mon_want.filtered, out_if.filtered_pressure);
            fail_count++;
          end
          if (out_if.control_error !== mon_want.ctl_err) begin
            $error("control_error: expected %0d, got %0d",
                   mon_want.ctl_err, out_if.control_error);
            fail_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pressure_filter_pid_step verification failed");
      $finish;
    end
  end

  task automatic queue_tick(input logic [pfpid_pkg::RAW_W-1:0] raw,
                            input logic signed [pfpid_pkg::PRES_W-1:0] target);
    pending_ticks.push_back('{raw: raw, target: target});
    ticks_in_flight++;
  endtask

  // sender holds off until every queued tick has its result checked
  task automatic wait_drained();
    do @(posedge clk_i); while (ticks_in_flight != 0);
  endtask

  // one register write transfer, mirrored into the predictor's copy
  task automatic write_reg(input logic [pfpid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pfpid_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      pfpid_pkg::REG_RAW_LOW:     regs.raw_low         = val[pfpid_pkg::RAW_W-1:0];
      pfpid_pkg::REG_RAW_HIGH:    regs.raw_high        = val[pfpid_pkg::RAW_W-1:0];
      pfpid_pkg::REG_COUNT_SCALE: regs.count_scale     = val;
      pfpid_pkg::REG_PRES_OFFSET: regs.pressure_offset = val;
      pfpid_pkg::REG_FILT_ALPHA:  regs.filter_alpha    = val[pfpid_pkg::ALPHA_W-1:0];
      pfpid_pkg::REG_GAIN_P:      regs.gain_p          = val[pfpid_pkg::GAIN_W-1:0];
      pfpid_pkg::REG_GAIN_I:      regs.gain_i          = val[pfpid_pkg::GAIN_W-1:0];
      default:                    regs.gain_d          = val[pfpid_pkg::GAIN_W-1:0];
    endcase
  endtask

  // mostly moderate settings so the loop leaves saturation, now and then extremes
  task automatic random_setting();
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    pick = $urandom_range(7);
    lo = (pick == 0) ? 0 : $urandom_range(20000);
    hi = (pick == 1) ? 65535 : $urandom_range(65535, lo);
    if (pick == 2) begin
      // inverted raw range
      lo = $urandom_range(65535, 30000);
      hi = $urandom_range(29999);
    end
    write_reg(pfpid_pkg::REG_RAW_LOW, lo);
    write_reg(pfpid_pkg::REG_RAW_HIGH, hi);
    write_reg(pfpid_pkg::REG_COUNT_SCALE,
              (pick == 3) ? $urandom : $urandom_range(32'h0002_0000));
    write_reg(pfpid_pkg::REG_PRES_OFFSET,
              (pick == 4) ? $urandom : $urandom_range(400 * 65536) - 200 * 65536);
    write_reg(pfpid_pkg::REG_FILT_ALPHA,
              (pick == 5) ? $urandom_range(131071, 65536) : $urandom_range(65536));
    write_reg(pfpid_pkg::REG_GAIN_P, (pick == 6) ? $urandom : $urandom_range(32'h0003_0000));
    write_reg(pfpid_pkg::REG_GAIN_I, (pick == 6) ? $urandom : $urandom_range(32'h0000_4000));
    write_reg(pfpid_pkg::REG_GAIN_D, (pick == 7) ? $urandom : $urandom_range(32'h0002_0000));
  endtask

  // targets mostly near the pressure range, sometimes anywhere in 32 bits
  function automatic logic signed [pfpid_pkg::PRES_W-1:0] random_target();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(600 * 65536) - 300 * 65536;
  endfunction

  initial begin
    int phase;
    int grp;
    int n;
    rst_ni                = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = pfpid_pkg::REG_RAW_LOW;
    cfg_if.data           = '0;
    in_if.valid           = 1'b0;
    in_if.raw_sample      = '0;
    in_if.target_pressure = '0;
    out_if.ready          = 1'b0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    ticks_in_flight       = 0;
    fail_count            = 0;
    cycle_count           = 0;

    // register defaults and cleared loop state
    regs.raw_low         = '0;
    regs.raw_high        = 16'hFFFF;
    regs.count_scale     = 32'h0100_0000;
    regs.pressure_offset = '0;
    regs.filter_alpha    = 17'd6554;
    regs.gain_p          = '0;
    regs.gain_i          = '0;
    regs.gain_d          = '0;
    smooth_kpa           = '0;
    integ_kpa            = '0;
    prev_err             = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: zero gains give zero drive; full scale pressure saturates, error saturates
    queue_tick(16'h0000, 32'sh0000_0000);
    queue_tick(16'hFFFF, 32'sh7FFF_FFFF);
    queue_tick(16'hFFFF, 32'sh8000_0000);
    wait_drained();

    // unit P gain, I gain 1/16, D gain 1/2, 1/16 kPa per count, -100 kPa offset, no smoothing
    write_reg(pfpid_pkg::REG_GAIN_P, 32'h0001_0000);
    write_reg(pfpid_pkg::REG_GAIN_I, 32'h0000_1000);
    write_reg(pfpid_pkg::REG_GAIN_D, 32'h0000_8000);
    write_reg(pfpid_pkg::REG_FILT_ALPHA, 32'h0001_0000);
    write_reg(pfpid_pkg::REG_COUNT_SCALE, 32'h0010_0000);
    write_reg(pfpid_pkg::REG_PRES_OFFSET, -32'sd6553600);
    // large positive error winds the integral up to its upper limit
    queue_tick(16'd0, 32'sd0);
    queue_tick(16'd0, 32'sd0);
    queue_tick(16'd0, 32'sd0);
    queue_tick(16'd1600, 32'sd0);
    queue_tick(16'd1632, -32'sd32768);
    // error saturation both ways, integral swings to its lower limit
    queue_tick(16'd0, 32'sh7FFF_FFFF);
    queue_tick(16'hFFFF, 32'sh8000_0000);
    queue_tick(16'hFFFF, 32'sh8000_0000);
    wait_drained();

    // inverted raw range with a huge scale, weight above one
    write_reg(pfpid_pkg::REG_RAW_LOW, 32'd40000);
    write_reg(pfpid_pkg::REG_RAW_HIGH, 32'd1000);
    write_reg(pfpid_pkg::REG_COUNT_SCALE, 32'hFFFF_FFFF);
    write_reg(pfpid_pkg::REG_FILT_ALPHA, 32'h0001_FFFF);
    queue_tick(16'd0, 32'sd0);
    queue_tick(16'd39999, 32'sd0);
    queue_tick(16'd40000, 32'sd0);
    queue_tick(16'hFFFF, 32'sd0);
    wait_drained();

    // full range, largest scale, offset and gains; weight zero freezes the filter
    write_reg(pfpid_pkg::REG_RAW_LOW, 32'd0);
    write_reg(pfpid_pkg::REG_RAW_HIGH, 32'hFFFF);
    write_reg(pfpid_pkg::REG_PRES_OFFSET, 32'h7FFF_FFFF);
    write_reg(pfpid_pkg::REG_GAIN_P, 32'hFFFF_FFFF);
    write_reg(pfpid_pkg::REG_GAIN_I, 32'h00FF_FFFF);
    write_reg(pfpid_pkg::REG_GAIN_D, 32'h00FF_FFFF);
    write_reg(pfpid_pkg::REG_FILT_ALPHA, 32'd0);
    queue_tick(16'hFFFF, 32'sh8000_0000);
    queue_tick(16'h0000, 32'sh7FFF_FFFF);
    wait_drained();
    write_reg(pfpid_pkg::REG_FILT_ALPHA, 32'h0001_0000);
    queue_tick(16'hFFFF, 32'sh8000_0000);
    queue_tick(16'h0000, 32'sh7FFF_FFFF);
    queue_tick(16'h5555, 32'sh5555_5555);
    queue_tick(16'hAAAA, 32'shAAAA_AAAA);

    // random part: four idling phases, each through several settings
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      for (grp = 0; grp < 5; grp++) begin
        // settings change only once the loop has gone quiet
        wait_drained();
        random_setting();
        for (n = 0; n < 35; n++) begin
          queue_tick(pfpid_pkg::RAW_W'($urandom_range(65535)), random_target());
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (expected_outs.size() != 0) begin
      $error("%0d expected results never arrived", expected_outs.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("pressure_filter_pid_step verification clean");
    end else begin
      $display("pressure_filter_pid_step verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pfpid_pkg.sv
sv/pfpid_intf.sv
sv/pfpid_regs.sv
sv/pfpid_ctrl.sv
sv/pfpid_dp.sv
sv/pressure_filter_pid_step.sv
sv/pfpid_checker.sv
test/tb.sv
